### sv/cdr_pkg.sv
// Shared types, codes and widths for the constrained dof renumbering block.
package cdr_pkg;

    localparam int DOF_W            = 12;
    localparam int CNT_W            = 13;
    localparam int DOF_RANGE        = 1 << DOF_W;
    localparam int MAX_DOFS_DEFAULT = 4096;
    localparam int CFG_IDX_W        = 2;
    localparam int IN_TDATA_W       = 24;
    localparam int OUT_TDATA_W      = 16;
    localparam int OUT_TUSER_W      = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_DOFS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_EQUATIONS = 2'd1;

    typedef enum logic [1:0] {
        CMD_MARK     = 2'd0,
        CMD_RENUMBER = 2'd1,
        CMD_CLEAR    = 2'd2,
        CMD_NONE     = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_DOF_RANGE = 2'd1,
        STATUS_EQ_RANGE  = 2'd2,
        STATUS_COUNTS    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    typedef struct packed {
        logic             dependent;
        logic [DOF_W-1:0] equation;
    } entry_t;

    typedef struct packed {
        logic [DOF_W-1:0] new_number;
        logic             is_dependent;
        status_t          status;
    } result_t;

    typedef struct packed {
        logic             wr_en;
        logic             rd_en;
        logic [DOF_W-1:0] addr;
        entry_t           wr_data;
    } tbl_req_t;

endpackage

### sv/cdr_table.sv
// Dof status table: single-port synchronous RAM with registered read data.
module cdr_table #(
    parameter int DEPTH  = cdr_pkg::MAX_DOFS_DEFAULT,
    parameter int ADDR_W = cdr_pkg::DOF_W
) (
    input  logic              clk,
    input  cdr_pkg::tbl_req_t req,
    output cdr_pkg::entry_t   rd_data
);
    import cdr_pkg::*;

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.addr[ADDR_W-1:0]] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data <= mem[req.addr[ADDR_W-1:0]];
        end
    end

endmodule

### sv/cdr_outq.sv
// Two-entry result queue that drives the master-side stream.
module cdr_outq (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    input  cdr_pkg::result_t                push_data,
    output logic                            full,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [cdr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic [cdr_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);
    import cdr_pkg::*;

    result_t    slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       pop;
    result_t    head;

    assign pop  = m_axis_tvalid && m_axis_tready;
    assign full = (count_reg == 2'd2);
    assign head = slot_reg[rd_ptr_reg];

    assign m_axis_tvalid = (count_reg != 2'd0);
    assign m_axis_tdata  = {(OUT_TDATA_W - DOF_W)'(0), head.new_number};
    assign m_axis_tuser  = {head.status, head.is_dependent};

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### sv/cdr_ctrl.sv
// Sequencer: command decode, range checks, counter, table sweep and result build.
module cdr_ctrl #(
    parameter int MAX_DOFS = cdr_pkg::MAX_DOFS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  cdr_pkg::cmd_t                 s_cmd,
    input  logic [cdr_pkg::DOF_W-1:0]     s_dof,
    input  logic [cdr_pkg::DOF_W-1:0]     s_eq,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cdr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cdr_pkg::CNT_W-1:0]     cfg_data,
    input  logic                          q_full,
    output logic                          push,
    output cdr_pkg::result_t              push_data,
    output cdr_pkg::tbl_req_t             tbl_req,
    input  cdr_pkg::entry_t               tbl_rd_data
);
    import cdr_pkg::*;

    localparam int TABLE_DEPTH = (MAX_DOFS < DOF_RANGE) ? MAX_DOFS : DOF_RANGE;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_DEPTH - 1);

    state_t            state_reg;
    state_t            state_next;
    logic [ADDR_W-1:0] sweep_addr_reg;
    logic [ADDR_W-1:0] sweep_addr_next;
    logic              sweep_cmd_reg;
    logic              sweep_cmd_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CNT_W-1:0]  total_reg;
    logic [CNT_W-1:0]  neq_reg;

    logic              accept;
    logic              bad_counts;
    logic              dof_bad;
    logic              eq_bad;
    logic              dep_eq_bad;
    logic              indep_full;
    logic              sweep_last;
    logic [CNT_W-1:0]  num_indep;
    logic [CNT_W-1:0]  dep_sum;

    assign cfg_ready  = 1'b1;
    assign s_tready   = (state_reg == ST_IDLE) && !q_full;
    assign accept     = s_tvalid && s_tready;
    assign sweep_last = (sweep_addr_reg == LAST_ADDR);

    assign bad_counts = (neq_reg > total_reg) || (32'(total_reg) > MAX_DOFS);
    assign dof_bad    = ({1'b0, s_dof} >= total_reg);
    assign eq_bad     = ({1'b0, s_eq} >= neq_reg);
    assign num_indep  = total_reg - neq_reg;
    assign dep_eq_bad = ({1'b0, tbl_rd_data.equation} >= neq_reg);
    assign dep_sum    = num_indep + {1'b0, tbl_rd_data.equation};
    assign indep_full = (count_reg >= num_indep);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_SWEEP:
            begin
                if (sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_cmd == CMD_CLEAR)
                    begin
                        state_next = ST_SWEEP;
                    end
                    else if (s_cmd == CMD_RENUMBER && !bad_counts && !dof_bad)
                    begin
                        state_next = ST_LOOKUP;
                    end
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_SWEEP;
            end
        endcase
    end

    // Outputs, table access and counter updates
    always_comb
    begin
        tbl_req                = '0;
        push                   = 1'b0;
        push_data.new_number   = '0;
        push_data.is_dependent = 1'b0;
        push_data.status       = STATUS_OK;
        count_next             = count_reg;
        sweep_addr_next        = sweep_addr_reg;
        sweep_cmd_next         = sweep_cmd_reg;
        unique case (state_reg)
            ST_SWEEP:
            begin
                tbl_req.wr_en   = 1'b1;
                tbl_req.addr    = DOF_W'(sweep_addr_reg);
                sweep_addr_next = sweep_addr_reg + ADDR_W'(1);
                if (sweep_last)
                begin
                    // report the clear only once the table is blank
                    push            = sweep_cmd_reg;
                    sweep_cmd_next  = 1'b0;
                    sweep_addr_next = '0;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (s_cmd) inside
                        CMD_CLEAR:
                        begin
                            count_next      = '0;
                            sweep_cmd_next  = 1'b1;
                            sweep_addr_next = '0;
                        end
                        CMD_NONE:
                        begin
                            push = 1'b1;
                        end
                        CMD_MARK, CMD_RENUMBER:
                        begin
                            if (bad_counts)
                            begin
                                push             = 1'b1;
                                push_data.status = STATUS_COUNTS;
                            end
                            else if (dof_bad)
                            begin
                                push             = 1'b1;
                                push_data.status = STATUS_DOF_RANGE;
                            end
                            else if (s_cmd == CMD_MARK)
                            begin
                                push = 1'b1;
                                if (eq_bad)
                                begin
                                    push_data.status = STATUS_EQ_RANGE;
                                end
                                else
                                begin
                                    tbl_req.wr_en             = 1'b1;
                                    tbl_req.addr              = s_dof;
                                    tbl_req.wr_data.dependent = 1'b1;
                                    tbl_req.wr_data.equation  = s_eq;
                                end
                            end
                            else
                            begin
                                tbl_req.rd_en = 1'b1;
                                tbl_req.addr  = s_dof;
                            end
                        end
                        default:
                        begin
                            push = 1'b0;
                        end
                    endcase
                end
            end
            ST_LOOKUP:
            begin
                push = 1'b1;
                if (tbl_rd_data.dependent)
                begin
                    if (dep_eq_bad)
                    begin
                        push_data.status = STATUS_EQ_RANGE;
                    end
                    else
                    begin
                        push_data.new_number   = dep_sum[DOF_W-1:0];
                        push_data.is_dependent = 1'b1;
                    end
                end
                else if (indep_full)
                begin
                    push_data.status = STATUS_COUNTS;
                end
                else
                begin
                    push_data.new_number = count_reg[DOF_W-1:0];
                    count_next           = count_reg + CNT_W'(1);
                end
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_SWEEP;
            sweep_addr_reg <= '0;
            sweep_cmd_reg  <= 1'b0;
            count_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            sweep_addr_reg <= sweep_addr_next;
            sweep_cmd_reg  <= sweep_cmd_next;
            count_reg      <= count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            neq_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_TOTAL_DOFS:    total_reg <= cfg_data;
                CFG_NUM_EQUATIONS: neq_reg   <= cfg_data;
                default:           total_reg <= total_reg;
            endcase
        end
    end

endmodule

### sv/constrained_dof_renumbering_top.sv
// Constrained dof renumbering: stream in, stream out, plus a register write channel.
//
// Input beats (s_axis) carry one command each: tuser selects mark, renumber or
// clear, tdata carries the dof number and the equation index. Every accepted
// beat produces exactly one result beat on m_axis: the new number, a dependent
// flag and a status code.
// Registers total_dofs (index 0) and num_equations (index 1) are written on
// the cfg channel, which is always ready; write them only while idle.
// A mark, an invalid command or a rejected command is answered from the idle
// state; a renumber reads the table, and its result is built in the lookup
// state from the registered read data. A clear walks the whole table of
// min(MAX_DOFS, 4096) entries, one entry a cycle, and its result appears at the end.
// After reset the same clearing pass runs over the whole table with
// s_axis_tready low and no result.
// Results queue in a two-entry buffer; while it is full because the receiver
// stalls, s_axis_tready stays low and nothing is lost.
module constrained_dof_renumbering_top #(
    parameter int MAX_DOFS = cdr_pkg::MAX_DOFS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [11:0] dof_number, [23:12] equation_index
    input  logic [cdr_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // [1:0] cmd
    input  logic [1:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [11:0] new_number, [15:12] zero
    output logic [cdr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // [0] is_dependent, [2:1] status
    output logic [cdr_pkg::OUT_TUSER_W-1:0] m_axis_tuser,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cdr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cdr_pkg::CNT_W-1:0]       cfg_data
);
    import cdr_pkg::*;

    localparam int TABLE_DEPTH = (MAX_DOFS < DOF_RANGE) ? MAX_DOFS : DOF_RANGE;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);

    logic     q_full;
    logic     push;
    result_t  push_data;
    tbl_req_t tbl_req;
    entry_t   tbl_rd_data;

    cdr_ctrl #(
        .MAX_DOFS (MAX_DOFS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_axis_tvalid),
        .s_tready    (s_axis_tready),
        .s_cmd       (cmd_t'(s_axis_tuser)),
        .s_dof       (s_axis_tdata[DOF_W-1:0]),
        .s_eq        (s_axis_tdata[2*DOF_W-1:DOF_W]),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .q_full      (q_full),
        .push        (push),
        .push_data   (push_data),
        .tbl_req     (tbl_req),
        .tbl_rd_data (tbl_rd_data)
    );

    cdr_table #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_table (
        .clk     (clk),
        .req     (tbl_req),
        .rd_data (tbl_rd_data)
    );

    cdr_outq u_outq (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .push_data     (push_data),
        .full          (q_full),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

### sv/cdr_checker.sv
// Port-level assertions for the renumbering block, bound to the top level.
module cdr_port_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [1:0]                      s_axis_tuser,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [cdr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [cdr_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);
    import cdr_pkg::*;

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

    // a rejected command reports no number and no dependent flag
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser[2:1] != STATUS_OK) |->
            (m_axis_tdata == '0) && !m_axis_tuser[0])
    else $error("error result carries a number");

    // the dependent flag only comes with an ok status
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> (m_axis_tuser[2:1] == STATUS_OK))
    else $error("dependent flag with error status");

    // a clear occupies the block for at least the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_CLEAR) |=>
            !s_axis_tready)
    else $error("input taken during table sweep");

endmodule

bind constrained_dof_renumbering_top cdr_port_checker u_cdr_checker (.*);
